// ===== src/nbge_pkg.sv =====
// Shared types, widths, constants and helpers of the n-body gravity step core.
`default_nettype none
package nbge_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COEF_FRAC = 24;
    localparam int NUM_SHIFT = 2 * FRAC_BITS - COEF_FRAC;
    localparam int DATA_W = 32;
    localparam int MAG_W = DATA_W + 1;
    localparam int SQ_W = 2 * MAG_W;
    localparam int ROOT_W = SQ_W / 2;
    localparam int MA_W = SQ_W;
    localparam int MB_W = MAG_W;
    localparam int MP_W = MA_W + MB_W;
    localparam int NUM_W = MP_W + NUM_SHIFT;
    localparam int TERM_W = 41;
    localparam int ACC_W = 48;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] REG_GRAV = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DT   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_EPS  = 2'd2;

    localparam logic [DATA_W-1:0] GRAV_RST = 32'd16777216;
    localparam logic [DATA_W-1:0] DT_RST   = 32'd167772;
    localparam logic [DATA_W-1:0] EPS_RST  = 32'd6554;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic [DATA_W-1:0]        mass;
    } t_body;

    typedef enum logic [4:0] {
        S_IDLE, S_EPS, S_SCAN, S_DIFF, S_MSQX, S_MSQY, S_SQRT, S_MR3, S_MGM,
        S_MNX, S_DX, S_MNY, S_DY, S_ROT, S_AX, S_AY, S_PX, S_PY
    } t_state;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(33'sh0_7FFF_FFFF);
        lo = -ACC_W'(33'sh0_8000_0000);
        if (v > hi) return 32'sh7FFF_FFFF;
        else if (v < lo) return 32'sh8000_0000;
        else return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // base + sign * (prod >> COEF_FRAC), saturated
    function automatic logic signed [DATA_W-1:0] advance(
        input logic signed [DATA_W-1:0] base,
        input logic                     neg,
        input logic [2*DATA_W-1:0]      prod
    );
        logic [2*DATA_W-COEF_FRAC-1:0] d;
        logic signed [ACC_W-1:0]       dd;
        d  = prod[2*DATA_W-1:COEF_FRAC];
        dd = signed'(ACC_W'(d));
        return sat32(ACC_W'(base) + (neg ? -dd : dd));
    endfunction
endpackage
`default_nettype wire

// ===== src/nbge_cell.sv =====
// One body cell of the rotating body chain.
`default_nettype none
module nbge_cell (
    input  wire                  i_clk,
    input  wire                  i_shift,
    input  nbge_pkg::t_body      i_body,
    output nbge_pkg::t_body      o_body
);
    import nbge_pkg::*;

    t_body r_body;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_body <= i_body;
        end
    end

    assign o_body = r_body;
endmodule
`default_nettype wire

// ===== src/nbge_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module nbge_mul (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [nbge_pkg::MA_W-1:0]  i_a,
    input  wire  [nbge_pkg::MB_W-1:0]  i_b,
    output logic                       o_done,
    output logic [nbge_pkg::MP_W-1:0]  o_prod
);
    import nbge_pkg::*;
    localparam int CW = $clog2(MB_W);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [MA_W-1:0] r_a;
    logic [MB_W-1:0] r_b;
    logic [MP_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MB_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[MP_W-2:0], 1'b0} + (r_b[MB_W-1] ? MP_W'(r_a) : '0);
            r_b   <= {r_b[MB_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

// ===== src/nbge_sqrt.sv =====
// Digit-by-digit integer square root, rounded down, one root bit per cycle.
`default_nettype none
module nbge_sqrt (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [nbge_pkg::SQ_W-1:0]    i_rad,
    output logic                         o_done,
    output logic [nbge_pkg::ROOT_W-1:0]  o_root
);
    import nbge_pkg::*;
    localparam int CW = $clog2(ROOT_W);
    localparam int RW = ROOT_W + 3;

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [SQ_W-1:0]   r_sh;
    logic [RW-1:0]     r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [RW-1:0]     w_try;
    logic [RW-1:0]     w_trial;
    logic              w_fit;

    assign w_try   = {r_rem[ROOT_W:0], r_sh[SQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_fit   = w_try >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh   <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_sh   <= {r_sh[SQ_W-3:0], 2'b00};
            r_rem  <= w_fit ? (w_try - w_trial) : w_try;
            r_root <= {r_root[ROOT_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== src/nbge_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^40.
`default_nettype none
module nbge_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [nbge_pkg::NUM_W-1:0]   i_num,
    input  wire  [nbge_pkg::MP_W-1:0]    i_den,
    output logic                         o_done,
    output logic [nbge_pkg::TERM_W-1:0]  o_quo
);
    import nbge_pkg::*;
    localparam int CW = $clog2(NUM_W);
    localparam logic [TERM_W-1:0] TERM_LIM = TERM_W'(1) << (TERM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_n;
    logic [NUM_W-1:0] r_q;
    logic [MP_W-1:0]  r_d;
    logic [MP_W-1:0]  r_rem;
    logic [MP_W:0]    w_try;
    logic             w_fit;
    logic [MP_W:0]    w_sub;

    assign w_try = {r_rem, r_n[NUM_W-1]};
    assign w_fit = w_try >= {1'b0, r_d};
    assign w_sub = w_try - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_d   <= i_den;
            r_q   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[NUM_W-2:0], 1'b0};
            r_rem <= w_fit ? w_sub[MP_W-1:0] : w_try[MP_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = ((|r_q[NUM_W-1:TERM_W]) || (r_q[TERM_W-1:0] > TERM_LIM)) ?
                    TERM_LIM : r_q[TERM_W-1:0];
endmodule
`default_nettype wire

// ===== src/nbody_gravity_euler_step_core.sv =====
// Top level: body chain, step sequencer and shared serial arithmetic units.
// Load: one item per cycle while o_busy is low; the marked item starts the step.
// Step: n+1 sweeps of MAX_BODIES slots, a scan and a rotate state a slot, plus six
// multiplies, a root and two divides per interacting pair, four multiplies per body.
// One result per body on o_valid, in load order; the receiver cannot stall.
// Sync active-low reset empties the store, idles the sequencer, restores registers.
`default_nettype none
module nbody_gravity_euler_step_core #(
    parameter int MAX_BODIES = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    output logic                             o_busy,
    input  wire  signed [nbge_pkg::DATA_W-1:0] i_pos_x_in,
    input  wire  signed [nbge_pkg::DATA_W-1:0] i_pos_y_in,
    input  wire  signed [nbge_pkg::DATA_W-1:0] i_vel_x_in,
    input  wire  signed [nbge_pkg::DATA_W-1:0] i_vel_y_in,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_mass_in,
    input  wire                              i_last_body_in,
    input  wire                              i_cfg_we,
    input  wire  [nbge_pkg::CIDX_W-1:0]      i_cfg_idx,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_cfg_data,
    output logic                             o_valid,
    output logic signed [nbge_pkg::DATA_W-1:0] o_pos_x_out,
    output logic signed [nbge_pkg::DATA_W-1:0] o_pos_y_out,
    output logic signed [nbge_pkg::DATA_W-1:0] o_vel_x_out,
    output logic signed [nbge_pkg::DATA_W-1:0] o_vel_y_out,
    output logic [nbge_pkg::DATA_W-1:0]      o_mass_out,
    output logic                             o_last_body_out
);
    import nbge_pkg::*;
    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam int IDX_W = $clog2(MAX_BODIES);

    t_state  r_state, n_state;
    logic    r_issued, n_issued;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_s, n_s;
    logic [IDX_W-1:0] r_hj, n_hj;
    logic [DATA_W-1:0] r_g, r_dt, r_eps;
    logic [2*DATA_W-1:0] r_eps2, n_eps2;
    t_body   r_tgt, n_tgt, r_nxt, n_nxt;
    logic [MAG_W-1:0] r_mdx, n_mdx, r_mdy, n_mdy;
    logic    r_nx, n_nx, r_ny, n_ny;
    logic [SQ_W-1:0] r_sqx, n_sqx, r_r2, n_r2;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [MP_W-1:0] r_r3, n_r3;
    logic [2*DATA_W-1:0] r_gm, n_gm;
    logic signed [ACC_W-1:0] r_ax, n_ax, r_ay, n_ay;
    logic signed [DATA_W-1:0] r_vx, n_vx, r_vy, n_vy, r_px, n_px;
    logic    r_o_valid, n_o_valid, r_o_last, n_o_last;
    t_body   r_o_body, n_o_body;

    t_body   w_cell_q [MAX_BODIES];
    t_body   w_cell_d [MAX_BODIES];
    t_body   w_in_body, w_head;
    logic    w_accept, w_load, w_rot, w_shift;
    logic    w_mul_go, w_mul_done, w_sqrt_go, w_sqrt_done, w_div_go, w_div_done;
    logic [MA_W-1:0] w_mul_a;
    logic [MB_W-1:0] w_mul_b;
    logic [MP_W-1:0] w_prod;
    logic [ROOT_W-1:0] w_root;
    logic [TERM_W-1:0] w_quo;
    logic [CNT_W-1:0] w_base, w_hj_ext, w_j;
    logic    w_in_set;
    logic signed [MAG_W-1:0] w_dx, w_dy;
    logic signed [DATA_W-1:0] w_ax32, w_ay32;
    logic signed [ACC_W-1:0] w_term;

    assign w_in_body = '{pos_x: i_pos_x_in, pos_y: i_pos_y_in, vel_x: i_vel_x_in,
                         vel_y: i_vel_y_in, mass: i_mass_in};
    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_load   = w_accept && (r_cnt < CNT_W'(MAX_BODIES));
    assign w_shift  = w_load || w_rot;
    assign w_head   = w_cell_q[0];

    // chain rotates toward cell 0; new bodies enter at the tail
    for (genvar k = 0; k < MAX_BODIES; k++) begin : g_cell
        if (k == MAX_BODIES - 1) begin : g_tail
            assign w_cell_d[k] = w_load ? w_in_body : w_cell_q[0];
        end else begin : g_mid
            assign w_cell_d[k] = w_cell_q[k+1];
        end
        nbge_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_body  (w_cell_d[k]),
            .o_body  (w_cell_q[k])
        );
    end

    nbge_mul u_mul (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_mul_go),
        .i_a (w_mul_a), .i_b (w_mul_b), .o_done (w_mul_done), .o_prod (w_prod)
    );

    nbge_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_sqrt_go),
        .i_rad (r_r2), .o_done (w_sqrt_done), .o_root (w_root)
    );

    nbge_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_go),
        .i_num ({w_prod, NUM_SHIFT'(0)}), .i_den (r_r3),
        .o_done (w_div_done), .o_quo (w_quo)
    );

    // slot hj holds body hj - (MAX - n) once the loaded bodies are reached
    assign w_base   = CNT_W'(MAX_BODIES) - r_cnt;
    assign w_hj_ext = CNT_W'(r_hj);
    assign w_in_set = w_hj_ext >= w_base;
    assign w_j      = w_hj_ext - w_base;

    assign w_dx   = MAG_W'(w_head.pos_x) - MAG_W'(r_tgt.pos_x);
    assign w_dy   = MAG_W'(w_head.pos_y) - MAG_W'(r_tgt.pos_y);
    assign w_ax32 = sat32(r_ax);
    assign w_ay32 = sat32(r_ay);
    assign w_term = signed'(ACC_W'(w_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g   <= GRAV_RST;
            r_dt  <= DT_RST;
            r_eps <= EPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRAV: r_g   <= i_cfg_data;
                REG_DT:   r_dt  <= i_cfg_data;
                REG_EPS:  r_eps <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issued  <= 1'b0;
            r_cnt     <= '0;
            r_s       <= '0;
            r_hj      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issued  <= n_issued;
            r_cnt     <= n_cnt;
            r_s       <= n_s;
            r_hj      <= n_hj;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eps2   <= n_eps2;
        r_tgt    <= n_tgt;
        r_nxt    <= n_nxt;
        r_mdx    <= n_mdx;
        r_mdy    <= n_mdy;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_sqx    <= n_sqx;
        r_r2     <= n_r2;
        r_root   <= n_root;
        r_r3     <= n_r3;
        r_gm     <= n_gm;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_px     <= n_px;
        r_o_last <= n_o_last;
        r_o_body <= n_o_body;
    end

    always_comb begin
        n_state   = r_state;
        n_issued  = r_issued;
        n_cnt     = r_cnt;
        n_s       = r_s;
        n_hj      = r_hj;
        n_eps2    = r_eps2;
        n_tgt     = r_tgt;
        n_nxt     = r_nxt;
        n_mdx     = r_mdx;
        n_mdy     = r_mdy;
        n_nx      = r_nx;
        n_ny      = r_ny;
        n_sqx     = r_sqx;
        n_r2      = r_r2;
        n_root    = r_root;
        n_r3      = r_r3;
        n_gm      = r_gm;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_vx      = r_vx;
        n_vy      = r_vy;
        n_px      = r_px;
        n_o_valid = 1'b0;
        n_o_last  = r_o_last;
        n_o_body  = r_o_body;
        w_rot     = 1'b0;
        w_mul_go  = 1'b0;
        w_sqrt_go = 1'b0;
        w_div_go  = 1'b0;
        w_mul_a   = '0;
        w_mul_b   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_load) n_cnt = r_cnt + 1'b1;
                    if (i_last_body_in) begin
                        n_state  = S_EPS;
                        n_s      = '0;
                        n_hj     = '0;
                        n_issued = 1'b0;
                    end
                end
            end
            S_EPS: begin
                w_mul_a  = MA_W'(r_eps);
                w_mul_b  = MB_W'(r_eps);
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_eps2   = w_prod[2*DATA_W-1:0];
                    n_issued = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_in_set && w_j == r_s) n_nxt = w_head;
                if (w_in_set && r_s != '0 && w_j != r_s - 1'b1) n_state = S_DIFF;
                else n_state = S_ROT;
            end
            S_DIFF: begin
                n_nx    = w_dx[MAG_W-1];
                n_ny    = w_dy[MAG_W-1];
                n_mdx   = w_dx[MAG_W-1] ? MAG_W'(-w_dx) : MAG_W'(w_dx);
                n_mdy   = w_dy[MAG_W-1] ? MAG_W'(-w_dy) : MAG_W'(w_dy);
                n_state = S_MSQX;
            end
            S_MSQX: begin
                w_mul_a  = MA_W'(r_mdx);
                w_mul_b  = r_mdx;
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_sqx    = w_prod[SQ_W-1:0];
                    n_issued = 1'b0;
                    n_state  = S_MSQY;
                end
            end
            S_MSQY: begin
                w_mul_a  = MA_W'(r_mdy);
                w_mul_b  = r_mdy;
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_r2     = r_sqx + w_prod[SQ_W-1:0] + SQ_W'(r_eps2);
                    n_issued = 1'b0;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                // coincident bodies with no softening add nothing
                if (r_r2 == '0) begin
                    n_state = S_ROT;
                end else begin
                    w_sqrt_go = !r_issued;
                    n_issued  = 1'b1;
                    if (w_sqrt_done) begin
                        n_root   = w_root;
                        n_issued = 1'b0;
                        n_state  = S_MR3;
                    end
                end
            end
            S_MR3: begin
                w_mul_a  = r_r2;
                w_mul_b  = r_root;
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_r3     = w_prod;
                    n_issued = 1'b0;
                    n_state  = S_MGM;
                end
            end
            S_MGM: begin
                w_mul_a  = MA_W'(r_g);
                w_mul_b  = MB_W'(w_head.mass);
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_gm     = w_prod[2*DATA_W-1:0];
                    n_issued = 1'b0;
                    n_state  = S_MNX;
                end
            end
            S_MNX: begin
                w_mul_a  = MA_W'(r_gm);
                w_mul_b  = r_mdx;
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_issued = 1'b0;
                    n_state  = S_DX;
                end
            end
            S_DX: begin
                w_div_go = !r_issued;
                n_issued = 1'b1;
                if (w_div_done) begin
                    n_ax     = r_nx ? r_ax - w_term : r_ax + w_term;
                    n_issued = 1'b0;
                    n_state  = S_MNY;
                end
            end
            S_MNY: begin
                w_mul_a  = MA_W'(r_gm);
                w_mul_b  = r_mdy;
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_issued = 1'b0;
                    n_state  = S_DY;
                end
            end
            S_DY: begin
                w_div_go = !r_issued;
                n_issued = 1'b1;
                if (w_div_done) begin
                    n_ay     = r_ny ? r_ay - w_term : r_ay + w_term;
                    n_issued = 1'b0;
                    n_state  = S_ROT;
                end
            end
            S_ROT: begin
                w_rot = 1'b1;
                if (r_hj == IDX_W'(MAX_BODIES - 1)) begin
                    // chain is back in load position: sweep done
                    n_hj = '0;
                    if (r_s == '0) begin
                        n_tgt   = r_nxt;
                        n_s     = CNT_W'(1);
                        n_ax    = '0;
                        n_ay    = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_AX;
                    end
                end else begin
                    n_hj    = r_hj + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_AX: begin
                w_mul_a  = MA_W'(mag32(w_ax32));
                w_mul_b  = MB_W'(r_dt);
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_vx     = advance(r_tgt.vel_x, w_ax32[DATA_W-1], w_prod[2*DATA_W-1:0]);
                    n_issued = 1'b0;
                    n_state  = S_AY;
                end
            end
            S_AY: begin
                w_mul_a  = MA_W'(mag32(w_ay32));
                w_mul_b  = MB_W'(r_dt);
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_vy     = advance(r_tgt.vel_y, w_ay32[DATA_W-1], w_prod[2*DATA_W-1:0]);
                    n_issued = 1'b0;
                    n_state  = S_PX;
                end
            end
            S_PX: begin
                w_mul_a  = MA_W'(mag32(r_vx));
                w_mul_b  = MB_W'(r_dt);
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_px     = advance(r_tgt.pos_x, r_vx[DATA_W-1], w_prod[2*DATA_W-1:0]);
                    n_issued = 1'b0;
                    n_state  = S_PY;
                end
            end
            S_PY: begin
                w_mul_a  = MA_W'(mag32(r_vy));
                w_mul_b  = MB_W'(r_dt);
                w_mul_go = !r_issued;
                n_issued = 1'b1;
                if (w_mul_done) begin
                    n_issued       = 1'b0;
                    n_o_valid      = 1'b1;
                    n_o_last       = (r_s == r_cnt);
                    n_o_body.pos_x = r_px;
                    n_o_body.pos_y = advance(r_tgt.pos_y, r_vy[DATA_W-1],
                                             w_prod[2*DATA_W-1:0]);
                    n_o_body.vel_x = r_vx;
                    n_o_body.vel_y = r_vy;
                    n_o_body.mass  = r_tgt.mass;
                    if (r_s == r_cnt) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_s     = r_s + 1'b1;
                        n_tgt   = r_nxt;
                        n_ax    = '0;
                        n_ay    = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_pos_x_out     = r_o_body.pos_x;
    assign o_pos_y_out     = r_o_body.pos_y;
    assign o_vel_x_out     = r_o_body.vel_x;
    assign o_vel_y_out     = r_o_body.vel_y;
    assign o_mass_out      = r_o_body.mass;
    assign o_last_body_out = r_o_last;
endmodule
`default_nettype wire

// ===== dv/nbge_step_checker.sv =====
// Checker for the n-body step core: mirrors the body store, predicts each step and compares.
`default_nettype none
module nbge_step_checker #(
    parameter int MAX_BODIES = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire                              i_busy,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_pos_x,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_pos_y,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_vel_x,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_vel_y,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_mass,
    input  wire                              i_last,
    input  wire                              i_cfg_we,
    input  wire  [nbge_pkg::CIDX_W-1:0]      i_cfg_idx,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_cfg_data,
    input  wire                              i_valid,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_res_pos_x,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_res_pos_y,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_res_vel_x,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_res_vel_y,
    input  wire  [nbge_pkg::DATA_W-1:0]      i_res_mass,
    input  wire                              i_res_last,
    output int                               o_errors,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nbge_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] pos_x;
        logic [DATA_W-1:0] pos_y;
        logic [DATA_W-1:0] vel_x;
        logic [DATA_W-1:0] vel_y;
        logic [DATA_W-1:0] mass;
        logic              last;
    } t_update;

    localparam logic [127:0] TERM_CLAMP = 128'd1 << 40;

    logic [DATA_W-1:0] grav, dt, eps;
    longint            st_px [MAX_BODIES];
    longint            st_py [MAX_BODIES];
    longint            st_vx [MAX_BODIES];
    longint            st_vy [MAX_BODIES];
    logic [63:0]       st_m  [MAX_BODIES];
    int                n_loaded;
    t_update           expected_updates[$];

    assign o_pending = expected_updates.size();

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // base + sign(rate) * ((|rate| * dt) >> 24)
    function automatic longint euler(longint base, longint rate, logic [63:0] step);
        logic [63:0] m;
        longint      d;
        m = (rate < 0) ? 64'(-rate) : 64'(rate);
        d = longint'((m * step) >> COEF_FRAC);
        return clamp32(base + ((rate < 0) ? -d : d));
    endfunction

    function automatic logic [127:0] root_floor(logic [127:0] v);
        logic [127:0] res, c;
        res = '0;
        for (int b = 34; b >= 0; b--) begin
            c = res | (128'd1 << b);
            if (v >= c * c) res = c;
        end
        return res;
    endfunction

    function automatic longint pull_term(longint d, logic [63:0] gm, logic [127:0] r3);
        logic [127:0] num, q;
        logic [63:0]  md;
        md  = (d < 0) ? 64'(-d) : 64'(d);
        num = ({64'd0, gm} * {64'd0, md}) << NUM_SHIFT;
        q   = num / r3;
        if (q > TERM_CLAMP) q = TERM_CLAMP;
        return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    task automatic predict_step();
        longint       ax, ay, dx, dy, vx, vy, px, py;
        logic [127:0] eps2, r2, r, r3;
        logic [63:0]  mdx, mdy, gm;
        t_update      u;
        eps2 = {96'd0, eps} * {96'd0, eps};
        for (int i = 0; i < n_loaded; i++) begin
            ax = 0;
            ay = 0;
            for (int j = 0; j < n_loaded; j++) begin
                if (j != i) begin
                    dx  = st_px[j] - st_px[i];
                    dy  = st_py[j] - st_py[i];
                    mdx = (dx < 0) ? 64'(-dx) : 64'(dx);
                    mdy = (dy < 0) ? 64'(-dy) : 64'(dy);
                    r2  = {64'd0, mdx} * {64'd0, mdx} + {64'd0, mdy} * {64'd0, mdy} + eps2;
                    // coincident pair with no softening pulls nothing
                    if (r2 != 0) begin
                        r  = root_floor(r2);
                        r3 = r2 * r;
                        gm = {32'd0, grav} * st_m[j];
                        ax += pull_term(dx, gm, r3);
                        ay += pull_term(dy, gm, r3);
                    end
                end
            end
            ax = clamp32(ax);
            ay = clamp32(ay);
            vx = euler(st_vx[i], ax, {32'd0, dt});
            vy = euler(st_vy[i], ay, {32'd0, dt});
            px = euler(st_px[i], vx, {32'd0, dt});
            py = euler(st_py[i], vy, {32'd0, dt});
            u.pos_x = px[31:0];
            u.pos_y = py[31:0];
            u.vel_x = vx[31:0];
            u.vel_y = vy[31:0];
            u.mass  = st_m[i][31:0];
            u.last  = (i + 1 == n_loaded);
            expected_updates.push_back(u);
        end
        n_loaded = 0;
    endtask

    task automatic cmp(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_update u;
        if (!i_rst_n) begin
            grav     = GRAV_RST;
            dt       = DT_RST;
            eps      = EPS_RST;
            n_loaded = 0;
            o_errors = 0;
            expected_updates.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRAV: grav = i_cfg_data;
                    REG_DT:   dt = i_cfg_data;
                    REG_EPS:  eps = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (expected_updates.size() == 0) begin
                    $display("%0t: unexpected body update, actual pos_x %h", $time,
                             i_res_pos_x);
                    o_errors++;
                end else begin
                    u = expected_updates.pop_front();
                    cmp("pos_x", u.pos_x, i_res_pos_x);
                    cmp("pos_y", u.pos_y, i_res_pos_y);
                    cmp("vel_x", u.vel_x, i_res_vel_x);
                    cmp("vel_y", u.vel_y, i_res_vel_y);
                    cmp("mass", u.mass, i_res_mass);
                    cmp("last", 32'(u.last), 32'(i_res_last));
                end
            end
            if (i_start && !i_busy) begin
                // a full store drops the body but still honors its last mark
                if (n_loaded < MAX_BODIES) begin
                    st_px[n_loaded] = longint'(signed'(i_pos_x));
                    st_py[n_loaded] = longint'(signed'(i_pos_y));
                    st_vx[n_loaded] = longint'(signed'(i_vel_x));
                    st_vy[n_loaded] = longint'(signed'(i_vel_y));
                    st_m[n_loaded]  = {32'd0, i_mass};
                    n_loaded++;
                end
                if (i_last) predict_step();
            end
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb_nbody_gravity_euler_step_core.sv =====
// Testbench top: drives bodies and register writes into the step core and reports the verdict.
`default_nettype none
module tb_nbody_gravity_euler_step_core;
    timeunit 1ns;
    timeprecision 1ps;
    import nbge_pkg::*;

    localparam int NBODY = 64;
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [DATA_W-1:0]  i_pos_x_in = '0, i_pos_y_in = '0, i_vel_x_in = '0, i_vel_y_in = '0;
    logic [DATA_W-1:0]  i_mass_in = '0;
    logic               i_last_body_in = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]  i_cfg_idx = '0;
    logic [DATA_W-1:0]  i_cfg_data = '0;
    logic               o_valid;
    logic [DATA_W-1:0]  o_pos_x_out, o_pos_y_out, o_vel_x_out, o_vel_y_out, o_mass_out;
    logic               o_last_body_out;
    int                 n_errors, n_pending, n_sent;

    always #4 i_clk = ~i_clk;

    nbody_gravity_euler_step_core #(.MAX_BODIES(NBODY)) dut (
        .i_clk, .i_rst_n, .i_start, .o_busy,
        .i_pos_x_in, .i_pos_y_in, .i_vel_x_in, .i_vel_y_in, .i_mass_in, .i_last_body_in,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_valid, .o_pos_x_out, .o_pos_y_out, .o_vel_x_out, .o_vel_y_out, .o_mass_out,
        .o_last_body_out
    );

    nbge_step_checker #(.MAX_BODIES(NBODY)) u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_pos_x(i_pos_x_in), .i_pos_y(i_pos_y_in), .i_vel_x(i_vel_x_in),
        .i_vel_y(i_vel_y_in), .i_mass(i_mass_in), .i_last(i_last_body_in),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(o_valid), .i_res_pos_x(o_pos_x_out), .i_res_pos_y(o_pos_y_out),
        .i_res_vel_x(o_vel_x_out), .i_res_vel_y(o_vel_y_out), .i_res_mass(o_mass_out),
        .i_res_last(o_last_body_out), .o_errors(n_errors), .o_pending(n_pending)
    );

    // hold one item until the core takes it, then maybe idle
    task automatic send_body(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                             logic [31:0] vy, logic [31:0] m, logic last, int gap);
        i_start        <= 1'b1;
        i_pos_x_in     <= px;
        i_pos_y_in     <= py;
        i_vel_x_in     <= vx;
        i_vel_y_in     <= vy;
        i_mass_in      <= m;
        i_last_body_in <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        n_sent++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0 || o_busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_reg(logic [31:0] dflt);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return $urandom_range(0, 32'h0100_0000);
            default: return dflt;
        endcase
    endfunction

    function automatic logic [31:0] small_val(int span);
        return 32'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic random_body(logic last, int gap);
        if ($urandom_range(0, 6) == 0)
            send_body($urandom, $urandom, $urandom, $urandom, $urandom, last, gap);
        else
            send_body(small_val(32'h8_0000), small_val(32'h8_0000), small_val(32'h4_0000),
                      small_val(32'h4_0000), $urandom_range(0, 32'h10_0000), last, gap);
    endtask

    initial begin
        int nb, gap;
        n_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single body drifts
        send_body(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h8000_0000, 32'h10000, 1, 0);
        drain();
        // coincident bodies with zero softening, plus a massless body
        write_reg(REG_EPS, 32'd0);
        send_body(32'h0003_0000, 32'h0003_0000, 32'd0, 32'd0, 32'h0002_0000, 0, 0);
        send_body(32'h0003_0000, 32'h0003_0000, 32'h1000, 32'd0, 32'h0004_0000, 0, 1);
        send_body(32'h0005_0000, 32'h0001_0000, 32'd0, 32'h1000, 32'd0, 1, 0);
        drain();
        // extremes with strong gravity and long step
        write_reg(REG_GRAV, 32'hFFFF_FFFF);
        write_reg(REG_DT, 32'hFFFF_FFFF);
        write_reg(REG_EPS, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  0, 0);
        send_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  0, 2);
        send_body(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 1, 0);
        drain();
        write_reg(REG_EPS, 32'd0);
        write_reg(REG_DT, 32'd0);
        send_body(32'd1, 32'd0, 32'd5, 32'd5, 32'hFFFF_FFFF, 0, 0);
        send_body(32'd0, 32'd0, 32'd5, 32'd5, 32'hFFFF_FFFF, 1, 0);
        drain();
        write_reg(REG_GRAV, GRAV_RST);
        write_reg(REG_DT, DT_RST);
        write_reg(REG_EPS, EPS_RST);

        // full store: the extra marked body is dropped but still starts the step
        for (int i = 0; i < NBODY; i++) random_body(0, (i % 8 == 0) ? $urandom_range(0, 6) : 0);
        random_body(1, 0);
        drain();

        nb = 0;
        while (n_sent < 460) begin
            if (nb % 8 == 0) begin
                write_reg(REG_GRAV, pick_reg(GRAV_RST));
                write_reg(REG_DT, pick_reg(DT_RST));
                write_reg(REG_EPS, pick_reg(EPS_RST));
            end
            nb = $urandom_range(1, 6);
            for (int i = 0; i < nb; i++) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                random_body(i == nb - 1, gap);
            end
            drain();
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #400ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
